// ----- sv/kvt_pkg.sv -----
// Package for the linear key/value table: operation and status codes,
// sequencer states and the compare result struct. No dependencies.
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_CHANGE = 2'd3
    } kvt_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_PAIR      = 3'd1,
        ST_KEY       = 3'd2,
        ST_VALUE     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5
    } kvt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } kvt_state_t;

    typedef struct packed {
        logic key_hit;
        logic value_hit;
    } kvt_match_t;

endpackage

// ----- sv/kvt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/kvt_match.sv -----
// Shared compare unit: tests one stored entry against the item's key and value.
// Depends on kvt_pkg for the match struct.
`timescale 1ns / 1ps

module kvt_match
    import kvt_pkg::*;
#(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic [KEY_WIDTH-1:0]   entry_key,
    input  logic [VALUE_WIDTH-1:0] entry_value,
    input  logic [KEY_WIDTH-1:0]   item_key,
    input  logic [VALUE_WIDTH-1:0] item_value,
    output kvt_match_t             hit
);

    assign hit.key_hit   = (entry_key == item_key);
    assign hit.value_hit = (entry_value == item_value);

endmodule

// ----- sv/key_value_table_linear_core.sv -----
// Top level of the linear key/value table: sequencer, entry RAM and result register.
// Depends on kvt_pkg, kvt_ram and kvt_match.
`timescale 1ns / 1ps

// The table holds up to DEPTH key/value pairs in order of entry, in one RAM
// with a single write port and a single registered read port. Each input word
// (add, delete, find or change) is handled on its own: the sequencer reads the
// held entries one a cycle through the one read port and tests each against
// the operands in a shared compare unit. An operation that meets a match at
// entry p, or finds none after the count entries held, then passes through the
// finish state to hand its result to the output register; a delete that hits
// entry p further copies every later entry down by one, one entry a cycle
// through the same port. The block takes no new input word until it is done
// with the last one. The result word sits in an output register, so the next
// input word is taken while a result still waits; a finished operation only
// stalls when the previous result has not yet been taken.
// Entries are never cleared: only entries below the count are ever used, so
// no reset pass over the RAM is needed.
module key_value_table_linear_core
    import kvt_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [OP_W-1:0]        s_operation,
    input  logic [KEY_WIDTH-1:0]   s_item_key,
    input  logic [VALUE_WIDTH-1:0] s_item_value,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic [VALUE_WIDTH-1:0] m_found_value,
    output logic [ENTRY_W-1:0]     m_entry_count
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = KEY_WIDTH + VALUE_WIDTH;

    // Sequencer and operand registers.
    kvt_state_t             state_reg, state_next;
    kvt_op_t                op_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // Result waiting to be handed to the output register.
    kvt_status_t            res_status_reg, res_status_next;
    logic [VALUE_WIDTH-1:0] res_found_reg, res_found_next;

    // Output register.
    logic                   out_valid_reg;
    kvt_status_t            out_status_reg;
    logic [VALUE_WIDTH-1:0] out_found_reg;
    logic [CNT_W-1:0]       out_count_reg;

    // RAM port.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_wr_addr;
    logic [WORD_W-1:0]      ram_wr_data;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [WORD_W-1:0]      ram_rd_data;
    logic [KEY_WIDTH-1:0]   entry_key;
    logic [VALUE_WIDTH-1:0] entry_value;

    kvt_match_t             hit;
    logic                   in_fire;
    logic                   out_free;
    logic                   entry_ok;
    logic                   last_entry;
    logic                   scan_hit;
    logic                   shift_more;
    logic [CNT_W-1:0]       idx_plus_one;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign entry_key   = ram_rd_data[WORD_W-1:VALUE_WIDTH];
    assign entry_value = ram_rd_data[VALUE_WIDTH-1:0];

    kvt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    kvt_match #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_match (
        .entry_key   (entry_key),
        .entry_value (entry_value),
        .item_key    (key_reg),
        .item_value  (value_reg),
        .hit         (hit)
    );

    // The read data in the scan state always belongs to entry idx_reg, and in
    // the shift state to entry idx_reg + 1. An entry only counts when it lies
    // below the count, which matters only when the table is empty.
    assign idx_plus_one = CNT_W'(idx_reg) + CNT_W'(1);
    assign entry_ok     = (CNT_W'(idx_reg) < count_reg);
    assign last_entry   = (idx_plus_one >= count_reg);
    assign shift_more   = (idx_plus_one < count_reg);

    always_comb begin
        unique case (op_reg)
            OP_ADD:    scan_hit = entry_ok && (hit.key_hit || hit.value_hit);
            OP_DELETE: scan_hit = entry_ok && hit.key_hit && hit.value_hit;
            default:   scan_hit = entry_ok && hit.key_hit;
        endcase
    end

    // Read address: entry 0 is fetched while idle so that the scan starts at
    // once; later each cycle fetches the entry needed in the next one.
    always_comb begin
        unique case (state_reg)
            S_SCAN:  ram_rd_addr = idx_reg + IDX_W'(1);
            S_SHIFT: ram_rd_addr = idx_reg + IDX_W'(2);
            default: ram_rd_addr = '0;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    state_next = (op_reg == OP_DELETE) ? S_SHIFT : S_FINISH;
                end else if (!entry_ok || last_entry) begin
                    state_next = S_FINISH;
                end
            end
            S_SHIFT: begin
                if (!shift_more) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath controls and table updates.
    always_comb begin
        ram_we          = 1'b0;
        ram_wr_addr     = idx_reg;
        ram_wr_data     = ram_rd_data;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    idx_next        = '0;
                    res_status_next = ST_OK;
                    res_found_next  = '0;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    unique case (op_reg)
                        OP_ADD: begin
                            priority if (hit.key_hit && hit.value_hit) begin
                                res_status_next = ST_PAIR;
                            end else if (hit.key_hit) begin
                                res_status_next = ST_KEY;
                            end else begin
                                res_status_next = ST_VALUE;
                            end
                        end
                        OP_DELETE: begin
                            res_status_next = ST_OK;
                        end
                        OP_FIND: begin
                            res_found_next = entry_value;
                        end
                        OP_CHANGE: begin
                            ram_we      = 1'b1;
                            ram_wr_data = {key_reg, value_reg};
                        end
                        default: ;
                    endcase
                end else if (!entry_ok || last_entry) begin
                    // No entry matched.
                    if (op_reg == OP_ADD) begin
                        if (count_reg < CNT_W'(DEPTH)) begin
                            ram_we      = 1'b1;
                            ram_wr_addr = count_reg[IDX_W-1:0];
                            ram_wr_data = {key_reg, value_reg};
                            count_next  = count_reg + CNT_W'(1);
                        end else begin
                            res_status_next = ST_FULL;
                        end
                    end else begin
                        res_status_next = ST_NOT_FOUND;
                    end
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_SHIFT: begin
                if (shift_more) begin
                    ram_we   = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_FINISH && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg    <= kvt_op_t'(s_operation);
            key_reg   <= s_item_key;
            value_reg <= s_item_value;
        end
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (state_reg == S_FINISH && out_free) begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_found_value = out_found_reg;
    assign m_entry_count = ENTRY_W'(out_count_reg);

endmodule

// ----- sv/kvt_checker.sv -----
// Port-level checker for the linear key/value table, bound to the top level.
// Depends on kvt_pkg and on key_value_table_linear_core for the bind.
`timescale 1ns / 1ps

module kvt_checker
    import kvt_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [OP_W-1:0]        s_operation,
    input logic [KEY_WIDTH-1:0]   s_item_key,
    input logic [VALUE_WIDTH-1:0] s_item_value,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [STATUS_W-1:0]    m_status,
    input logic [VALUE_WIDTH-1:0] m_found_value,
    input logic [ENTRY_W-1:0]     m_entry_count
);

    // An offered input word holds until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_operation)
            && $stable(s_item_key) && $stable(s_item_value))
        else $error("input word changed while waiting");

    // A waiting result word holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_found_value) && $stable(m_entry_count))
        else $error("result word changed while stalled");

    // The sequencer is busy in the cycle after it takes a word.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again straight after a word");

    // Only a successful find carries a stored value.
    a_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_found_value == '0)
        else $error("found value set on a failed operation");

    // The table never reports more entries than it can hold.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_entry_count) <= 32'(DEPTH))
        else $error("entry count beyond table depth");

endmodule

bind key_value_table_linear_core kvt_checker #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_kvt_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_operation   (s_operation),
    .s_item_key    (s_item_key),
    .s_item_value  (s_item_value),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_found_value (m_found_value),
    .m_entry_count (m_entry_count)
);

// ----- tb/tb.sv -----
// Self-checking testbench for key_value_table_linear_core: directed, full-table, random and
// back-pressure phases, checked against a behavioural model of the table held in the bench.
// Depends on kvt_pkg and the RTL of the key/value table.
`timescale 1ns / 1ps

module tb;
    import kvt_pkg::*;

    localparam int TABLE_DEPTH    = 16;
    localparam int KEY_W          = 32;
    localparam int VALUE_W        = 32;
    localparam int POOL_SIZE      = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_CYCLES     = 40;

    // One expected result word, as the model of the table predicts it.
    typedef struct {
        kvt_status_t          status;
        logic [VALUE_W-1:0]   found;
        logic [ENTRY_W-1:0]   count;
    } table_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_operation = '0;
    logic [KEY_W-1:0]       s_item_key = '0;
    logic [VALUE_W-1:0]     s_item_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_W-1:0]    m_status;
    logic [VALUE_W-1:0]     m_found_value;
    logic [ENTRY_W-1:0]     m_entry_count;

    // The bench's own copy of the table, updated as each word is accepted.
    logic [KEY_W-1:0]       tbl_key [TABLE_DEPTH];
    logic [VALUE_W-1:0]     tbl_value [TABLE_DEPTH];
    int                     tbl_count = 0;

    logic [KEY_W-1:0]       key_pool [POOL_SIZE];
    logic [VALUE_W-1:0]     value_pool [POOL_SIZE];

    table_result_t          pending_results [$];
    int                     errors = 0;
    int                     words_sent = 0;
    int                     results_checked = 0;
    int                     status_seen [6] = '{default: 0};

    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_len = 0;
    logic                   hold_toggle = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_left = 0;
    int                     quiet_cycles = 0;

    always #5 aclk = ~aclk;

    key_value_table_linear_core #(
        .DEPTH       (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_W),
        .VALUE_WIDTH (VALUE_W)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_item_key    (s_item_key),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_found_value (m_found_value),
        .m_entry_count (m_entry_count)
    );

    // Applies one operation to the bench's table and returns the result word it should give.
    // Add stops at the first entry whose key or value matches; the kind of match at that entry
    // decides the duplicate status, with an exact pair ranking above a key, and a key above a
    // value. Delete closes the gap by moving every later entry down by one.
    function automatic table_result_t apply_table_op(kvt_op_t op, logic [KEY_W-1:0] k,
                                                     logic [VALUE_W-1:0] v);
        table_result_t r;
        int hit;
        r.status = ST_OK;
        r.found  = '0;
        hit      = -1;
        case (op)
            OP_ADD: begin
                for (int i = 0; i < tbl_count && hit < 0; i++)
                    if (tbl_key[i] == k || tbl_value[i] == v)
                        hit = i;
                if (hit >= 0) begin
                    if (tbl_key[hit] == k && tbl_value[hit] == v)
                        r.status = ST_PAIR;
                    else if (tbl_key[hit] == k)
                        r.status = ST_KEY;
                    else
                        r.status = ST_VALUE;
                end else if (tbl_count == TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_key[tbl_count]   = k;
                    tbl_value[tbl_count] = v;
                    tbl_count++;
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < tbl_count && hit < 0; i++)
                    if (tbl_key[i] == k && tbl_value[i] == v)
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < tbl_count; i++) begin
                        tbl_key[i]   = tbl_key[i + 1];
                        tbl_value[i] = tbl_value[i + 1];
                    end
                    tbl_count--;
                end
            end
            default: begin
                // Find and change both look the key up; keys are unique in the table.
                for (int i = 0; i < tbl_count && hit < 0; i++)
                    if (tbl_key[i] == k)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else if (op == OP_FIND)
                    r.found = tbl_value[hit];
                else
                    tbl_value[hit] = v;
            end
        endcase
        r.count = ENTRY_W'(tbl_count);
        status_seen[int'(r.status)]++;
        return r;
    endfunction

    // Offers one word and holds it until the block takes it. The valid line is only lowered
    // when the sender chooses to idle, so back-to-back words never see it drop and rise
    // within the same time step.
    task automatic send_word(input kvt_op_t op, input logic [KEY_W-1:0] k,
                             input logic [VALUE_W-1:0] v);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_item_key   <= k;
        s_item_value <= v;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(apply_table_op(op, k, v));
        words_sent++;
    endtask

    // Lowers valid and waits for every predicted result to be taken.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
    endtask

    // Fresh keys and values for a phase. The extremes are always in the pools so that they
    // keep turning up in well-formed traffic as well as in the directed part.
    task automatic refill_pools();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i]   = $urandom;
            value_pool[i] = $urandom;
        end
        key_pool[0]   = '0;
        key_pool[1]   = '1;
        value_pool[0] = '0;
        value_pool[1] = '1;
    endtask

    // Chooses one random word. Most words draw their key and value from small pools, or from
    // entries that the table holds, so that duplicates, hits, shifts and a full table all turn
    // up often; the rest is noise over the whole range of every field.
    task automatic pick_word(output kvt_op_t op, output logic [KEY_W-1:0] k,
                             output logic [VALUE_W-1:0] v);
        int roll;
        int idx;
        roll = $urandom_range(99);
        if (roll < 12) begin
            op = kvt_op_t'($urandom_range(3));
            k  = $urandom;
            v  = $urandom;
        end else begin
            roll = $urandom_range(99);
            if (roll < 35)
                op = OP_ADD;
            else if (roll < 60)
                op = OP_DELETE;
            else if (roll < 80)
                op = OP_FIND;
            else
                op = OP_CHANGE;
            k = key_pool[$urandom_range(POOL_SIZE - 1)];
            v = value_pool[$urandom_range(POOL_SIZE - 1)];
            if (tbl_count > 0 && op != OP_ADD && $urandom_range(3) != 0) begin
                idx = $urandom_range(tbl_count - 1);
                k   = tbl_key[idx];
                if (op == OP_DELETE && $urandom_range(4) != 0)
                    v = tbl_value[idx];
            end
        end
    endtask

    // Lookups and deletes on an empty table, every duplicate status including the rule that
    // the first matching entry decides, a find that ignores its value operand, and a change
    // that leaves two entries with the same value.
    task automatic test_directed_ops();
        send_word(OP_FIND,   32'h0000_0005, 32'h0000_0005);
        send_word(OP_DELETE, 32'h0000_0005, 32'h0000_0005);
        send_word(OP_CHANGE, 32'h0000_0005, 32'h0000_0005);
        send_word(OP_ADD,    32'h0000_0000, 32'h0000_0000);
        send_word(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ADD,    32'h0000_0000, 32'h0000_0000);
        send_word(OP_ADD,    32'h0000_0000, 32'h0000_0001);
        send_word(OP_ADD,    32'h0000_0007, 32'hFFFF_FFFF);
        // Value matches entry 0 before the key matches entry 1, so the value status wins.
        send_word(OP_ADD,    32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
        send_word(OP_FIND,   32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_CHANGE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_FIND,   32'h0000_0000, 32'h0000_0000);
        send_word(OP_ADD,    32'h0000_0009, 32'hFFFF_FFFF);
        send_word(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(OP_FIND,   32'hFFFF_FFFF, 32'hA5A5_5A5A);
        wait_for_results();
    endtask

    // Fills the table to the last entry, adds once more to a full table, then deletes from
    // the middle and checks that the shifted entries are still found.
    task automatic test_table_full();
        for (int i = tbl_count; i < TABLE_DEPTH; i++)
            send_word(OP_ADD, 32'h1000_0000 + i, 32'h2000_0000 + i);
        send_word(OP_ADD,    32'h5555_AAAA, 32'hAAAA_5555);
        send_word(OP_DELETE, tbl_key[TABLE_DEPTH / 2], tbl_value[TABLE_DEPTH / 2]);
        send_word(OP_FIND,   tbl_key[TABLE_DEPTH - 2], 32'h0);
        send_word(OP_FIND,   tbl_key[TABLE_DEPTH / 2], 32'h0);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        kvt_op_t op;
        logic [KEY_W-1:0] k;
        logic [VALUE_W-1:0] v;
        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        refill_pools();
        for (int i = 0; i < n; i++) begin
            pick_word(op, k, v);
            send_word(op, k, v);
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender offers words without a
    // break, so the output register fills and the block has to refuse input.
    task automatic test_output_backpressure();
        kvt_op_t op;
        logic [KEY_W-1:0] k;
        logic [VALUE_W-1:0] v;
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_len    <= 300;
        hold_toggle <= ~hold_toggle;
        refill_pools();
        for (int i = 0; i < 100; i++) begin
            pick_word(op, k, v);
            send_word(op, k, v);
        end
        wait_for_results();
    endtask

    // Receiver: random stalls at the phase's rate, or a counted hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= hold_len;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every result word taken is compared field by field with the oldest prediction.
    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word: status %0d found %h count %0d",
                         $time, m_status, m_found_value, m_entry_count);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_status);
                    errors++;
                end
                if (m_found_value !== want.found) begin
                    $display("%0t: found_value mismatch: expected %h, actual %h",
                             $time, want.found, m_found_value);
                    errors++;
                end
                if (m_entry_count !== want.count) begin
                    $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                             $time, want.count, m_entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("key_value_table_linear_core test failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ops();
        test_table_full();
        test_random_traffic(360, 0, 0);
        test_random_traffic(360, 80, 0);
        test_random_traffic(360, 0, 80);
        test_random_traffic(360, 20, 20);
        test_output_backpressure();

        wait_for_results();
        repeat (END_CYCLES) @(posedge aclk);

        $display("Ran %0d operations with %0d results compared, across directed, full-table,",
                 words_sent, results_checked);
        $display("random and held-off phases; ok/pair/key/value/miss/full: %0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3], status_seen[4], status_seen[5]);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("key_value_table_linear_core test passed");
        end else begin
            $display("key_value_table_linear_core test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/kvt_pkg.sv
sv/kvt_ram.sv
sv/kvt_match.sv
sv/key_value_table_linear_core.sv
sv/kvt_checker.sv
tb/tb.sv
